/* rtl/ray_triangle_nearest_hit_top_assert.svh */
// Assertion macros for the nearest ray-triangle hit block.
// Used by ray_triangle_nearest_hit_top; expects i_clk and i_rst_n in scope.
`ifndef RAY_TRIANGLE_NEAREST_HIT_TOP_ASSERT_SVH
`define RAY_TRIANGLE_NEAREST_HIT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RTN_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtn same-cycle check failed");
// next-cycle implication
`define RTN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtn next-cycle check failed");
`else
`define RTN_ASSERT_SAME(lbl, ante, cons)
`define RTN_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/rtn_pkg.sv */
// Shared types, codes and sizes for the nearest ray-triangle hit block.
// No dependencies; imported by every module of the block.
package rtn_pkg;

    localparam int TRIANGLES   = 64;
    localparam int COORD_W     = 24;
    localparam int SLOT_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int VROW_DEPTH  = TRIANGLES * 3;
    localparam int VADDR_W     = $clog2(VROW_DEPTH);
    localparam int DIST_W      = 28;
    localparam int MUL_A_W     = 80;
    localparam int MUL_B_W     = 64;
    localparam int MUL_P_W     = 128;
    localparam int MUL_STEP    = 8;
    localparam int DIV_Q_W     = 32;
    localparam int SQ_W        = 64;
    localparam int ROOT_W      = 32;

    localparam logic [DIV_Q_W-1:0] HIT_CAP  = DIV_Q_W'(64'h4000_0000);
    localparam logic [DIST_W-1:0]  DIST_MAX = '1;

    localparam logic REQ_VERTEX = 1'b0;
    localparam logic REQ_RAY    = 1'b1;
    localparam logic [1:0] VERTEX_NONE = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic                  req_type;
        logic [SLOT_W-1:0]     triangle_slot;
        logic [1:0]            vertex_number;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } t_res;

    typedef enum logic [1:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_ORIGIN_Z,
        CFG_TRI_COUNT
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_WAIT,
        S_DIV,
        S_DIVW,
        S_SQRT,
        S_SQW,
        S_NEXT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_NORM,
        PH_NUM,
        PH_DEN,
        PH_PROD,
        PH_CU,
        PH_CW,
        PH_SIDE,
        PH_SQ
    } t_phase;

endpackage

/* rtl/rtn_mul.sv */
// Shared signed multiplier, one byte of the second operand per cycle.
// Depends on rtn_pkg.
module rtn_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [rtn_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [rtn_pkg::MUL_B_W-1:0]   i_b,
    output logic                                 o_done,
    output logic signed [rtn_pkg::MUL_P_W-1:0]   o_prod
);
    import rtn_pkg::*;

    localparam int STEPS = MUL_B_W / MUL_STEP;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [MUL_A_W-1:0]          r_am;
    logic [MUL_B_W-1:0]          r_bm;
    logic                        r_neg;
    logic signed [MUL_P_W-1:0]   r_acc;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [MUL_A_W+MUL_STEP-1:0] pp;

    // partial product of the magnitude by the top byte
    assign pp = r_am * r_bm[MUL_B_W-1 -: MUL_STEP];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: load magnitudes, shift-accumulate, then apply the sign
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_am  <= i_a[MUL_A_W-1] ? MUL_A_W'(-i_a) : MUL_A_W'(i_a);
            r_bm  <= i_b[MUL_B_W-1] ? MUL_B_W'(-i_b) : MUL_B_W'(i_b);
            r_neg <= i_a[MUL_A_W-1] ^ i_b[MUL_B_W-1];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_acc <= (r_acc << MUL_STEP) + MUL_P_W'(pp);
                r_bm  <= r_bm << MUL_STEP;
            end else if (r_neg) begin
                r_acc <= -r_acc;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* rtl/rtn_div.sv */
// Restoring divider for the hit-point coordinate, one quotient bit a cycle.
// Depends on rtn_pkg. A quotient of 2^31 or more shows with its top bit set.
module rtn_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [rtn_pkg::MUL_P_W-1:0]       i_num,
    input  logic [rtn_pkg::MUL_P_W-1:0]       i_den,
    output logic                              o_done,
    output logic [rtn_pkg::DIV_Q_W-1:0]       o_quot
);
    import rtn_pkg::*;

    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    logic [MUL_P_W-1:0] r_rem;
    logic [MUL_P_W-1:0] r_ds;
    logic [DIV_Q_W-1:0] r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic               ge;

    assign ge = (r_rem >= r_ds);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DIV_Q_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: compare, subtract, shift divisor down
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_ds  <= i_den << (DIV_Q_W - 1);
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            if (ge) begin
                r_rem <= r_rem - r_ds;
            end
            r_q  <= {r_q[DIV_Q_W-2:0], ge};
            r_ds <= r_ds >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* rtl/rtn_sqrt.sv */
// Integer square root, one result bit a cycle.
// Depends on rtn_pkg.
module rtn_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rtn_pkg::SQ_W-1:0]      i_val,
    output logic                          o_done,
    output logic [rtn_pkg::ROOT_W-1:0]    o_root
);
    import rtn_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [SQ_W-1:0]  r_v;
    logic [SQ_W-1:0]  r_r;
    logic [SQ_W-1:0]  r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [SQ_W-1:0]  trial;

    assign trial = r_r + r_bit;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(ROOT_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: try the next bit pair
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_r   <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (r_cnt != '0) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];

endmodule

/* rtl/ray_triangle_nearest_hit_top.sv */
// Top level of the nearest ray-triangle hit block: sequencer, vertex memory.
// Depends on rtn_pkg, rtn_mul, rtn_div, rtn_sqrt and the assertion header.
//
// Usage:
//   Input beats are taken when start is high and busy is low. A vertex write
//   (req_type 0) stores one vertex (none if vertex_number is 3), gives no
//   result and leaves busy low. A ray cast (req_type 1) raises busy, walks
//   triangles 0 .. min(triangle_count, 64)-1 from the configured origin and
//   ends with one beat on o_res marked by o_done for exactly one cycle; busy
//   is still high during that beat and drops after it.
//   Sequencing: every product goes through the shared byte-serial multiplier
//   (63 products per triangle that passes all tests), the divider runs once
//   per coordinate and the square root once per hit. A triangle is dropped
//   early when the ray is parallel to it, starts on its plane or meets it
//   behind the origin. The next beat can be taken once busy is low again. A
//   ray over zero triangles gives its result beat in the cycle right after
//   it is taken.
//   Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write one register per
//   cycle; write only while busy is low.
//   Reset clears configuration and sequencer; working values and vertex
//   contents are undefined until written. The receiver cannot stall o_res.
`include "ray_triangle_nearest_hit_top_assert.svh"
module ray_triangle_nearest_hit_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  rtn_pkg::t_req                     i_req,
    output logic                              busy,
    output logic                              o_done,
    output rtn_pkg::t_res                     o_res,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [rtn_pkg::COORD_W-1:0]       i_cfg_data
);
    import rtn_pkg::*;

    localparam int ROW_W = 3 * COORD_W;

    // configuration
    t_coord            r_org [3];
    logic [COUNT_W-1:0] r_tri_count;

    // sequencer
    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [2:0]         r_k, n_k;
    logic [1:0]         r_side, n_side;
    logic [1:0]         r_c, n_c;
    logic [1:0]         r_ld, n_ld;
    logic [SLOT_W-1:0]  r_t, n_t;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_any, n_any;
    logic [DIST_W-1:0]  r_best, n_best;

    // working values
    t_coord                  r_v [3][3];
    t_coord                  n_v [3][3];
    t_coord                  r_dir [3];
    t_coord                  n_dir [3];
    logic signed [51:0]      r_n [3];
    logic signed [51:0]      n_n [3];
    logic signed [79:0]      r_num, n_num, r_den, n_den;
    logic signed [31:0]      r_q [3];
    logic signed [31:0]      n_q [3];
    logic signed [32:0]      r_pt [3];
    logic signed [32:0]      n_pt [3];
    logic signed [59:0]      r_cu [3];
    logic signed [59:0]      n_cu [3];
    logic signed [51:0]      r_cw [3];
    logic signed [51:0]      n_cw [3];
    logic signed [MUL_P_W-1:0] r_acc, n_acc, acc_n;

    // vertex memory
    logic [ROW_W-1:0]   mem [VROW_DEPTH];
    logic [ROW_W-1:0]   r_rd;
    logic [VADDR_W-1:0] wr_addr, rd_addr;
    logic               mem_we;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      mul_sub, mul_done;
    logic signed [MUL_P_W-1:0] mul_prod;
    logic [MUL_P_W-1:0]        div_num, div_den;
    logic                      div_done;
    logic [DIV_Q_W-1:0]        div_quot;
    logic                      sq_done;
    logic [ROOT_W-1:0]         sq_root;

    // helpers for the sequencer
    logic [COUNT_W-1:0]        cnt_clamp;
    logic [79:0]               den_mag;
    logic [DIV_Q_W-1:0]        mag;
    logic signed [31:0]        qv;
    logic signed [32:0]        ptv;
    t_coord                    b_lo, b_hi;
    logic                      in_box;
    logic [DIST_W-1:0]         hit_dist;
    logic                      is_cross;

    // operand selection
    logic [1:0]                j, j1, j2, d, sa, sb, sc;
    logic signed [MUL_A_W-1:0] cx [3];
    logic signed [MUL_B_W-1:0] cy [3];

    function automatic logic [1:0] nxt3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]    <= '0;
            r_org[1]    <= '0;
            r_org[2]    <= '0;
            r_tri_count <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:  r_org[0]    <= i_cfg_data;
                CFG_ORIGIN_Y:  r_org[1]    <= i_cfg_data;
                CFG_ORIGIN_Z:  r_org[2]    <= i_cfg_data;
                CFG_TRI_COUNT: r_tri_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // vertex memory: one row is x, y, z of one vertex
    assign wr_addr = VADDR_W'({i_req.triangle_slot, 1'b0}) + VADDR_W'(i_req.triangle_slot)
                   + VADDR_W'(i_req.vertex_number);
    assign rd_addr = VADDR_W'({r_t, 1'b0}) + VADDR_W'(r_t) + VADDR_W'(r_ld);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= {i_req.coord_x, i_req.coord_y, i_req.coord_z};
        end
        r_rd <= mem[rd_addr];
    end

    // operand mux for the shared multiplier
    assign is_cross = (r_phase == PH_NORM) || (r_phase == PH_CU) || (r_phase == PH_CW);
    assign mul_sub  = is_cross && r_k[0];

    always_comb begin
        j  = r_k[2:1];
        j1 = nxt3(j);
        j2 = nxt3(j1);
        d  = r_k[1:0];
        unique case (r_side)
            2'd0:    begin sa = 2'd1; sb = 2'd2; sc = 2'd0; end
            2'd1:    begin sa = 2'd2; sb = 2'd0; sc = 2'd1; end
            default: begin sa = 2'd0; sb = 2'd1; sc = 2'd2; end
        endcase
        for (int i = 0; i < 3; i++) begin
            cx[i] = MUL_A_W'(r_v[sa][i]) - MUL_A_W'(r_v[sb][i]);
            cy[i] = MUL_B_W'(r_v[sc][i]) - MUL_B_W'(r_v[sb][i]);
            if (r_phase == PH_NORM) begin
                cx[i] = MUL_A_W'(r_v[1][i]) - MUL_A_W'(r_v[0][i]);
                cy[i] = MUL_B_W'(r_v[2][i]) - MUL_B_W'(r_v[0][i]);
            end else if (r_phase == PH_CU) begin
                cy[i] = MUL_B_W'(r_pt[i]) - MUL_B_W'(r_v[sb][i]);
            end
        end
        case (r_phase)
            PH_NUM: begin
                mul_a = MUL_A_W'(r_n[d]);
                mul_b = MUL_B_W'(r_v[0][d]) - MUL_B_W'(r_org[d]);
            end
            PH_DEN: begin
                mul_a = MUL_A_W'(r_n[d]);
                mul_b = MUL_B_W'(r_dir[d]);
            end
            PH_PROD: begin
                mul_a = MUL_A_W'(r_num);
                mul_b = MUL_B_W'(r_dir[r_c]);
            end
            PH_SIDE: begin
                mul_a = MUL_A_W'(r_cu[d]);
                mul_b = MUL_B_W'(r_cw[d]);
            end
            PH_SQ: begin
                mul_a = MUL_A_W'(r_q[d]);
                mul_b = MUL_B_W'(r_q[d]);
            end
            default: begin
                mul_a = r_k[0] ? cx[j2] : cx[j1];
                mul_b = r_k[0] ? cy[j1] : cy[j2];
            end
        endcase
    end

    assign acc_n = mul_sub ? (r_acc - mul_prod) : (r_acc + mul_prod);

    // divider operands and hit point for coordinate r_c
    assign den_mag = r_den[79] ? 80'(-r_den) : 80'(r_den);
    assign div_den = MUL_P_W'(den_mag);
    assign div_num = r_acc[MUL_P_W-1] ? MUL_P_W'(-r_acc) : MUL_P_W'(r_acc);
    assign mag     = (div_quot > HIT_CAP) ? HIT_CAP : div_quot;
    assign qv      = (r_acc[MUL_P_W-1] ^ r_den[79]) ? -$signed(mag) : $signed(mag);
    assign ptv     = 33'(r_org[r_c]) + 33'(qv);

    always_comb begin
        b_lo = r_v[0][r_c];
        b_hi = r_v[0][r_c];
        if (r_v[1][r_c] < b_lo) b_lo = r_v[1][r_c];
        if (r_v[2][r_c] < b_lo) b_lo = r_v[2][r_c];
        if (r_v[1][r_c] > b_hi) b_hi = r_v[1][r_c];
        if (r_v[2][r_c] > b_hi) b_hi = r_v[2][r_c];
        in_box = (ptv >= 33'(b_lo)) && (ptv <= 33'(b_hi));
    end

    assign hit_dist  = (sq_root > ROOT_W'(DIST_MAX)) ? DIST_MAX : sq_root[DIST_W-1:0];
    assign cnt_clamp = (r_tri_count > COUNT_W'(TRIANGLES)) ? COUNT_W'(TRIANGLES) : r_tri_count;

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_k     = r_k;
        n_side  = r_side;
        n_c     = r_c;
        n_ld    = r_ld;
        n_t     = r_t;
        n_count = r_count;
        n_any   = r_any;
        n_best  = r_best;
        n_v     = r_v;
        n_dir   = r_dir;
        n_n     = r_n;
        n_num   = r_num;
        n_den   = r_den;
        n_q     = r_q;
        n_pt    = r_pt;
        n_cu    = r_cu;
        n_cw    = r_cw;
        n_acc   = r_acc;
        mem_we  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_req.req_type == REQ_RAY) begin
                        n_dir[0] = i_req.coord_x;
                        n_dir[1] = i_req.coord_y;
                        n_dir[2] = i_req.coord_z;
                        n_count  = cnt_clamp;
                        n_any    = 1'b0;
                        n_best   = '0;
                        n_t      = '0;
                        n_ld     = '0;
                        n_state  = (cnt_clamp == '0) ? S_DONE : S_LOAD;
                    end else begin
                        mem_we = (i_req.vertex_number != VERTEX_NONE);
                    end
                end
            end
            S_LOAD: begin
                // issue three row reads, capture each in the cycle after its read
                n_ld = r_ld + 2'd1;
                if (r_ld != 2'd0) begin
                    n_v[r_ld - 2'd1][0] = r_rd[3*COORD_W-1 -: COORD_W];
                    n_v[r_ld - 2'd1][1] = r_rd[2*COORD_W-1 -: COORD_W];
                    n_v[r_ld - 2'd1][2] = r_rd[COORD_W-1:0];
                end
                if (r_ld == 2'd3) begin
                    n_phase = PH_NORM;
                    n_k     = '0;
                    n_acc   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (mul_done) begin
                    n_acc   = acc_n;
                    n_k     = r_k + 3'd1;
                    n_state = S_MUL;
                    case (r_phase)
                        PH_NORM: begin
                            if (r_k[0]) begin
                                n_n[j] = acc_n[51:0];
                                n_acc  = '0;
                                if (r_k == 3'd5) begin
                                    n_phase = PH_NUM;
                                    n_k     = '0;
                                end
                            end
                        end
                        PH_NUM: begin
                            if (r_k == 3'd2) begin
                                n_num   = acc_n[79:0];
                                n_acc   = '0;
                                n_k     = '0;
                                n_phase = PH_DEN;
                            end
                        end
                        PH_DEN: begin
                            if (r_k == 3'd2) begin
                                n_den = acc_n[79:0];
                                n_acc = '0;
                                n_k   = '0;
                                // drop parallel rays, origins on the plane and hits behind the origin
                                if (acc_n == '0 || r_num == '0
                                    || acc_n[MUL_P_W-1] != r_num[79]) begin
                                    n_state = S_NEXT;
                                end else begin
                                    n_phase = PH_PROD;
                                    n_c     = '0;
                                end
                            end
                        end
                        PH_PROD: begin
                            n_k     = '0;
                            n_state = S_DIV;
                        end
                        PH_CU: begin
                            if (r_k[0]) begin
                                n_cu[j] = acc_n[59:0];
                                n_acc   = '0;
                                if (r_k == 3'd5) begin
                                    n_phase = PH_CW;
                                    n_k     = '0;
                                end
                            end
                        end
                        PH_CW: begin
                            if (r_k[0]) begin
                                n_cw[j] = acc_n[51:0];
                                n_acc   = '0;
                                if (r_k == 3'd5) begin
                                    n_phase = PH_SIDE;
                                    n_k     = '0;
                                end
                            end
                        end
                        PH_SIDE: begin
                            if (r_k == 3'd2) begin
                                n_acc = '0;
                                n_k   = '0;
                                if (acc_n[MUL_P_W-1]) begin
                                    n_state = S_NEXT;
                                end else if (r_side == 2'd2) begin
                                    n_phase = PH_SQ;
                                end else begin
                                    n_side  = r_side + 2'd1;
                                    n_phase = PH_CU;
                                end
                            end
                        end
                        PH_SQ: begin
                            if (r_k == 3'd2) begin
                                n_state = S_SQRT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (div_done) begin
                    n_acc = '0;
                    if (!in_box) begin
                        n_state = S_NEXT;
                    end else begin
                        n_q[r_c]  = qv;
                        n_pt[r_c] = ptv;
                        n_state   = S_MUL;
                        if (r_c == 2'd2) begin
                            n_phase = PH_CU;
                            n_side  = '0;
                            n_k     = '0;
                        end else begin
                            n_c = r_c + 2'd1;
                        end
                    end
                end
            end
            S_SQRT: begin
                n_state = S_SQW;
            end
            S_SQW: begin
                if (sq_done) begin
                    if (!r_any || hit_dist < r_best) begin
                        n_best = hit_dist;
                    end
                    n_any   = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (({1'b0, r_t} + COUNT_W'(1)) == r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_t     = r_t + 1'b1;
                    n_ld    = '0;
                    n_state = S_LOAD;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_NORM;
            r_k     <= '0;
            r_side  <= '0;
            r_c     <= '0;
            r_ld    <= '0;
            r_t     <= '0;
            r_count <= '0;
            r_any   <= 1'b0;
            r_best  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_k     <= n_k;
            r_side  <= n_side;
            r_c     <= n_c;
            r_ld    <= n_ld;
            r_t     <= n_t;
            r_count <= n_count;
            r_any   <= n_any;
            r_best  <= n_best;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_dir <= n_dir;
        r_n   <= n_n;
        r_num <= n_num;
        r_den <= n_den;
        r_q   <= n_q;
        r_pt  <= n_pt;
        r_cu  <= n_cu;
        r_cw  <= n_cw;
        r_acc <= n_acc;
    end

    rtn_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    rtn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    rtn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQRT),
        .i_val   (r_acc[SQ_W-1:0]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // result beat
    assign busy           = (r_state != S_IDLE);
    assign o_done         = (r_state == S_DONE);
    assign o_res.hit      = r_any;
    assign o_res.distance = r_best;

    `RTN_ASSERT_NEXT(a_ray_goes_busy, start && !busy && i_req.req_type == REQ_RAY, busy)
    `RTN_ASSERT_NEXT(a_single_beat, o_done, !o_done)
    `RTN_ASSERT_SAME(a_done_while_busy, o_done, busy)
    `RTN_ASSERT_SAME(a_miss_zero_dist, o_done && !o_res.hit, o_res.distance == '0)

endmodule

/* verif/ray_triangle_nearest_hit_top_tb.sv */
// Testbench for the nearest ray-triangle hit block: directed and random
// vertex loads and ray casts, checked against an in-bench hit predictor.
// Depends on rtn_pkg and ray_triangle_nearest_hit_top.
module ray_triangle_nearest_hit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rtn_pkg::*;

    typedef logic signed [127:0] wide_t;
    localparam longint RUN_LIMIT = 20_000_000;
    localparam int     TAIL_CYCLES = 20;
    localparam int     SMALL_SLOTS = 8;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    t_req           i_req = '0;
    logic           busy;
    logic           o_done;
    t_res           o_res;
    logic           i_cfg_we = 1'b0;
    logic [1:0]     i_cfg_idx = '0;
    logic [COORD_W-1:0] i_cfg_data = '0;

    ray_triangle_nearest_hit_top dut (
        .i_clk, .i_rst_n, .start, .i_req, .busy, .o_done, .o_res,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    longint     vtx [TRIANGLES][3][3];
    longint     origin [3];
    int         tri_count;
    t_res       pending_hits [$];
    int         err_count = 0;
    logic       quiet = 1'b0;
    logic       busy_s = 1'b0;
    longint     cycles = 0;

    // sample busy mid-cycle so the edge decision does not race the block
    always @(negedge i_clk) busy_s <= busy;

    // check each result beat against the oldest prediction
    always @(negedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done) begin
            if (pending_hits.size() == 0) begin
                $error("unexpected result beat hit=%0d distance=%0d", o_res.hit, o_res.distance);
                err_count++;
            end else begin
                want = pending_hits.pop_front();
                if (o_res.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_res.hit);
                    err_count++;
                end
                if (o_res.distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, o_res.distance);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void cross3(input longint x[3], input longint y[3], output longint o[3]);
        o[0] = x[1] * y[2] - x[2] * y[1];
        o[1] = x[2] * y[0] - x[0] * y[2];
        o[2] = x[0] * y[1] - x[1] * y[0];
    endfunction

    function automatic wide_t dot3(input longint x[3], input longint y[3]);
        wide_t acc, a, b;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            a = x[k];
            b = y[k];
            acc += a * b;
        end
        return acc;
    endfunction

    // edge (a,b) with opposite vertex c: negative means p is outside
    function automatic logic outside_edge(input longint a[3], input longint b[3],
                                          input longint c[3], input longint p[3]);
        longint e[3], u[3], w[3], cu[3], cw[3];
        for (int k = 0; k < 3; k++) begin
            e[k] = a[k] - b[k];
            u[k] = p[k] - b[k];
            w[k] = c[k] - b[k];
        end
        cross3(e, u, cu);
        cross3(e, w, cw);
        return dot3(cu, cw) < 0;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // one triangle against the ray; returns 1 on a hit and its distance
    function automatic logic triangle_hit(input int slot, input longint dir[3],
                                          output logic [DIST_W-1:0] tri_dist);
        longint v0[3], v1[3], v2[3], e1[3], e2[3], rel[3], n[3], q[3], pt[3];
        wide_t num, den, p, dw;
        logic [127:0] ap, dm, m;
        logic [63:0] mag, sum, root;
        logic neg;
        longint lo, hi;
        tri_dist = '0;
        for (int c = 0; c < 3; c++) begin
            v0[c] = vtx[slot][0][c];
            v1[c] = vtx[slot][1][c];
            v2[c] = vtx[slot][2][c];
            e1[c] = v1[c] - v0[c];
            e2[c] = v2[c] - v0[c];
            rel[c] = v0[c] - origin[c];
        end
        cross3(e1, e2, n);
        num = dot3(n, rel);
        den = dot3(n, dir);
        if (den == 0 || num == 0 || ((num < 0) != (den < 0))) return 1'b0;
        dm = (den < 0) ? -den : den;
        for (int c = 0; c < 3; c++) begin
            dw = dir[c];
            p = num * dw;
            ap = (p < 0) ? -p : p;
            m = ap / dm;
            mag = (m > 128'(HIT_CAP)) ? 64'(HIT_CAP) : m[63:0];
            neg = (p < 0) != (den < 0);
            q[c] = neg ? -longint'(mag) : longint'(mag);
            pt[c] = origin[c] + q[c];
            lo = v0[c];
            hi = v0[c];
            if (v1[c] < lo) lo = v1[c];
            if (v2[c] < lo) lo = v2[c];
            if (v1[c] > hi) hi = v1[c];
            if (v2[c] > hi) hi = v2[c];
            if (pt[c] < lo || pt[c] > hi) return 1'b0;
        end
        if (outside_edge(v1, v2, v0, pt)) return 1'b0;
        if (outside_edge(v2, v0, v1, pt)) return 1'b0;
        if (outside_edge(v0, v1, v2, pt)) return 1'b0;
        sum = 0;
        for (int c = 0; c < 3; c++) sum += 64'(q[c] * q[c]);
        root = floor_sqrt(sum);
        tri_dist = (root > 64'(DIST_MAX)) ? DIST_MAX : root[DIST_W-1:0];
        return 1'b1;
    endfunction

    function automatic t_res nearest_hit(input t_req r);
        longint dir[3];
        logic [DIST_W-1:0] d, best;
        logic any;
        int n;
        t_res res;
        dir[0] = r.coord_x;
        dir[1] = r.coord_y;
        dir[2] = r.coord_z;
        n = (tri_count > TRIANGLES) ? TRIANGLES : tri_count;
        any = 1'b0;
        best = '0;
        for (int t = 0; t < n; t++) begin
            if (triangle_hit(t, dir, d)) begin
                if (!any || d < best) best = d;
                any = 1'b1;
            end
        end
        res.hit = any;
        res.distance = any ? best : '0;
        return res;
    endfunction

    // drive one beat and wait for the block to take it
    task automatic send_beat(input t_req r);
        if (!quiet && $urandom_range(99) < 13) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy_s);
        if (r.req_type == REQ_VERTEX) begin
            if (r.vertex_number != VERTEX_NONE) begin
                vtx[r.triangle_slot][r.vertex_number][0] = r.coord_x;
                vtx[r.triangle_slot][r.vertex_number][1] = r.coord_y;
                vtx[r.triangle_slot][r.vertex_number][2] = r.coord_z;
            end
        end else begin
            pending_hits = {pending_hits, nearest_hit(r)};
        end
    endtask

    // hold the sender until every result is back and the block settles
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input longint value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= COORD_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ORIGIN_X:  origin[0] = t_coord'(COORD_W'(value));
            CFG_ORIGIN_Y:  origin[1] = t_coord'(COORD_W'(value));
            CFG_ORIGIN_Z:  origin[2] = t_coord'(COORD_W'(value));
            CFG_TRI_COUNT: tri_count = int'(value) & 8'h7F;
        endcase
    endtask

    task automatic set_origin(input longint x, input longint y, input longint z);
        cfg_write(CFG_ORIGIN_X, x);
        cfg_write(CFG_ORIGIN_Y, y);
        cfg_write(CFG_ORIGIN_Z, z);
    endtask

    function automatic t_req vertex_beat(input int slot, input int vn,
                                         input longint x, input longint y, input longint z);
        t_req r;
        r.req_type = REQ_VERTEX;
        r.triangle_slot = SLOT_W'(slot);
        r.vertex_number = 2'(vn);
        r.coord_x = COORD_W'(x);
        r.coord_y = COORD_W'(y);
        r.coord_z = COORD_W'(z);
        return r;
    endfunction

    function automatic t_req ray_beat(input longint x, input longint y, input longint z);
        t_req r;
        r = vertex_beat(0, 0, x, y, z);
        r.req_type = REQ_RAY;
        r.triangle_slot = SLOT_W'($urandom);
        r.vertex_number = 2'($urandom);
        return r;
    endfunction

    function automatic longint rnd_span(input int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    function automatic longint rnd_full();
        return t_coord'(COORD_W'($urandom));
    endfunction

    // triangle scattered around a random center
    task automatic load_triangle(input int slot);
        longint cx, cy, cz;
        cx = rnd_span(1 << 21);
        cy = rnd_span(1 << 21);
        cz = rnd_span(1 << 21);
        for (int v = 0; v < 3; v++)
            send_beat(vertex_beat(slot, v, cx + rnd_span(1 << 18),
                                  cy + rnd_span(1 << 18), cz + rnd_span(1 << 18)));
    endtask

    // ray aimed near the centroid of a stored triangle
    task automatic cast_at(input int slot, input int jitter);
        longint d[3];
        for (int c = 0; c < 3; c++)
            d[c] = (vtx[slot][0][c] + vtx[slot][1][c] + vtx[slot][2][c]) / 3
                   - origin[c] + rnd_span(jitter);
        send_beat(ray_beat(d[0], d[1], d[2]));
    endtask

    // empty scene, register extremes
    task automatic test_empty_scene();
        set_origin(-8388608, 8388607, -8388608);
        cfg_write(CFG_TRI_COUNT, 0);
        send_beat(ray_beat(8388607, -8388608, 0));
        wait_idle();
        set_origin(8388607, -8388608, 8388607);
        send_beat(ray_beat(-8388608, 8388607, -1));
        wait_idle();
        set_origin(0, 0, 0);
    endtask

    // hand-built triangles: hit, edge, vertex, parallel, behind, degenerate
    task automatic test_directed_cases();
        // plane z = 4.0, triangle spanning x,y in [0,4]
        send_beat(vertex_beat(0, 0, 0, 0, 4 << 16));
        send_beat(vertex_beat(0, 1, 4 << 16, 0, 4 << 16));
        send_beat(vertex_beat(0, 2, 0, 4 << 16, 4 << 16));
        // bad vertex number: ignored
        send_beat(vertex_beat(0, VERTEX_NONE, 8388607, -8388608, 8388607));
        // degenerate triangle: all vertices equal
        send_beat(vertex_beat(1, 0, 1 << 16, 1 << 16, 2 << 16));
        send_beat(vertex_beat(1, 1, 1 << 16, 1 << 16, 2 << 16));
        send_beat(vertex_beat(1, 2, 1 << 16, 1 << 16, 2 << 16));
        wait_idle();
        cfg_write(CFG_TRI_COUNT, 2);
        send_beat(ray_beat(1 << 16, 1 << 16, 4 << 16));       // inside
        send_beat(ray_beat(2 << 16, 0, 4 << 16));             // on an edge
        send_beat(ray_beat(4 << 16, 0, 4 << 16));             // on a vertex
        send_beat(ray_beat(3 << 16, 3 << 16, 4 << 16));       // just outside
        send_beat(ray_beat(1 << 16, 1 << 16, 0));             // parallel
        send_beat(ray_beat(1 << 16, 1 << 16, -(4 << 16)));    // behind
        send_beat(ray_beat(1, 1, 1));                         // tiny direction
        send_beat(ray_beat(8388607, 8388607, 8388607));
        send_beat(ray_beat(-8388608, -8388608, -8388608));
        send_beat(ray_beat(1, 0, 8388607));                   // hit point at vertex 0
        wait_idle();
        // origin on the plane: numerator zero
        set_origin(1 << 16, 1 << 16, 4 << 16);
        send_beat(ray_beat(0, 0, 1 << 16));
        wait_idle();
        set_origin(0, 0, 0);
    endtask

    // small scenes with changing origin and count
    task automatic test_random_scenes();
        int pick;
        for (int s = 0; s < SMALL_SLOTS; s++) load_triangle(s);
        for (int ph = 0; ph < 18; ph++) begin
            wait_idle();
            quiet = (ph >= 6 && ph < 11);
            if (ph % 7 == 3) set_origin(8388607, -8388608, 8388607);
            else set_origin(rnd_span(1 << 21), rnd_span(1 << 21), rnd_span(1 << 21));
            cfg_write(CFG_TRI_COUNT, $urandom_range(1, 4));
            for (int k = 0; k < 40; k++) begin
                pick = $urandom_range(99);
                if (k == 20) wait_idle();
                if (pick < 15) load_triangle($urandom_range(SMALL_SLOTS - 1));
                else if (pick < 22)
                    send_beat(vertex_beat($urandom_range(SMALL_SLOTS - 1), $urandom_range(3),
                                          rnd_full(), rnd_full(), rnd_full()));
                else if (pick < 85)
                    cast_at($urandom_range(tri_count - 1), (pick < 50) ? 0 : (1 << 16));
                else send_beat(ray_beat(rnd_full(), rnd_full(), rnd_full()));
            end
        end
        quiet = 1'b0;
    endtask

    // full table, including a count above the table size
    task automatic test_full_table();
        for (int s = SMALL_SLOTS; s < TRIANGLES; s++) load_triangle(s);
        wait_idle();
        set_origin(rnd_span(1 << 20), rnd_span(1 << 20), rnd_span(1 << 20));
        cfg_write(CFG_TRI_COUNT, TRIANGLES);
        cast_at($urandom_range(TRIANGLES - 1), 0);
        cast_at($urandom_range(TRIANGLES - 1), 1 << 15);
        wait_idle();
        cfg_write(CFG_TRI_COUNT, 127);
        cast_at($urandom_range(TRIANGLES - 1), 0);
        send_beat(ray_beat(rnd_full(), rnd_full(), rnd_full()));
        wait_idle();
        cfg_write(CFG_TRI_COUNT, 65);
        cast_at($urandom_range(TRIANGLES - 1), 0);
    endtask

    initial begin
        for (int t = 0; t < TRIANGLES; t++)
            for (int v = 0; v < 3; v++)
                for (int c = 0; c < 3; c++) vtx[t][v][c] = 0;
        origin = '{0, 0, 0};
        tri_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_scene();
        test_directed_cases();
        test_random_scenes();
        test_full_table();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
